// ===== design/oaht_pkg.sv =====
package oaht_pkg;

  localparam logic [1:0] CMD_GET = 2'd0;
  localparam logic [1:0] CMD_SET = 2'd1;
  localparam logic [1:0] CMD_DEL = 2'd2;

  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_NOTFOUND = 2'd1;
  localparam logic [1:0] STS_FROZEN   = 2'd2;
  localparam logic [1:0] STS_FULL     = 2'd3;

  localparam logic [1:0] SLOT_EMPTY = 2'd0;
  localparam logic [1:0] SLOT_LIVE  = 2'd1;
  localparam logic [1:0] SLOT_TOMB  = 2'd2;

  localparam int HASH_W  = 32;
  localparam int KEY_W   = 32;
  localparam int VALUE_W = 64;
  localparam int SIDX_W  = 8;

  localparam logic [1:0] MOD_MUL = 2'd0;
  localparam logic [1:0] MOD_QUO = 2'd1;
  localparam logic [1:0] MOD_REM = 2'd2;

  typedef struct packed {
    logic [1:0]         status;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
  } slot_t;

  typedef struct packed {
    logic clr_step;
    logic load_item;
    logic mod_step;
    logic prime;
    logic probe_step;
    logic finish;
  } oaht_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic need_probe;
    logic mod_bypass;
    logic mod_last;
    logic probe_stop;
    logic out_free;
  } oaht_stat_t;

endpackage

// ===== design/oaht_ctrl.sv =====
module oaht_ctrl
  import oaht_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  oaht_stat_t stat,
  output oaht_cmd_t  cmd
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_MOD    = 3'd2;
  localparam logic [2:0] S_PRIME  = 3'd3;
  localparam logic [2:0] S_PROBE  = 3'd4;
  localparam logic [2:0] S_FINISH = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          if (!stat.need_probe) begin
            state_nxt = S_FINISH;
          end else if (stat.mod_bypass) begin
            state_nxt = S_PRIME;
          end else begin
            state_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_nxt = S_PRIME;
        end
      end
      S_PRIME: begin
        cmd.prime = 1'b1;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        cmd.probe_step = 1'b1;
        if (stat.probe_stop) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/oaht_dpath.sv =====
module oaht_dpath
  import oaht_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  oaht_cmd_t          cmd,
  output oaht_stat_t         stat,
  input  logic               frozen,
  input  logic               global_mode,
  input  logic [1:0]         in_cmd,
  input  logic [KEY_W-1:0]   in_key_id,
  input  logic [HASH_W-1:0]  in_key_hash,
  input  logic [VALUE_W-1:0] in_write_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic               out_is_new_key,
  output logic [VALUE_W-1:0] out_read_value,
  output logic [SIDX_W-1:0]  out_slot_index,
  output logic               out_slot_index_valid
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int LIMIT = CAPACITY * 3 / 4;
  localparam int CNT_W = $clog2(LIMIT + 1);
  localparam int SH_Q  = IDX_W - 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0] LIMIT_C  = CNT_W'(LIMIT);
  localparam bit POW2 = ((CAPACITY & (CAPACITY - 1)) == 0);
  localparam longint unsigned RECIP_L =
    ((((64'd1 << IDX_W) - 64'(CAPACITY)) << HASH_W) / 64'(CAPACITY)) + 64'd1;
  localparam logic [HASH_W-1:0] RECIP = HASH_W'(RECIP_L);
  localparam logic [HASH_W-1:0] CAP_H = HASH_W'(CAPACITY);

  slot_t mem [CAPACITY];
  slot_t rdata_r;

  logic [1:0]         cmd_r;
  logic [KEY_W-1:0]   key_r;
  logic [VALUE_W-1:0] val_r;
  logic [HASH_W-1:0]  hash_r;
  logic [IDX_W-1:0]   rem_r;
  logic [1:0]         mod_cnt_r;
  logic [HASH_W-1:0]  mh_r;
  logic [HASH_W-1:0]  quo_r;
  logic               probe_ran_r;

  logic [IDX_W-1:0]   clr_r;
  logic [IDX_W-1:0]   addr_r;
  logic [IDX_W-1:0]   ev_addr_r;
  logic [IDX_W-1:0]   visit_r;
  logic               tomb_seen_r;
  logic [IDX_W-1:0]   tomb_addr_r;
  logic               hit_r;
  logic               empty_r;
  logic [VALUE_W-1:0] hit_val_r;
  logic [CNT_W-1:0]   used_r;
  logic               out_valid_r;

  logic [2*HASH_W-1:0] mul_full;
  logic [HASH_W-1:0]  quo_sum;
  logic [HASH_W-1:0]  quo_nxt;
  logic [HASH_W-1:0]  quo_prod;
  logic [HASH_W-1:0]  rem_full;
  logic [IDX_W-1:0]   start_idx;
  logic [IDX_W-1:0]   base_addr;
  logic [IDX_W-1:0]   addr_inc;
  logic               slot_empty;
  logic               slot_match;
  logic               slot_tomb;
  logic               is_get;
  logic               is_set;
  logic               is_del;
  logic               room;
  logic               dst_ok;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  slot_t              mem_wdata;
  logic [IDX_W+7:0]   sidx_ext;
  logic [1:0]         res_status;
  logic               res_new;
  logic [VALUE_W-1:0] res_rval;
  logic               res_svalid;
  logic               need_probe;

  // start slot: mask for power-of-two sizes, else multiply by the reciprocal and subtract
  assign mul_full  = (2*HASH_W)'(RECIP) * (2*HASH_W)'(hash_r);
  assign quo_sum   = mh_r + ((hash_r - mh_r) >> 1);
  assign quo_nxt   = quo_sum >> SH_Q;
  assign quo_prod  = quo_r * CAP_H;
  assign rem_full  = hash_r - quo_prod;
  assign start_idx = POW2 ? hash_r[IDX_W-1:0] : rem_r;

  assign base_addr = cmd.prime ? start_idx : addr_r;
  assign addr_inc  = (base_addr == LAST_IDX) ? '0 : base_addr + 1'b1;

  assign slot_empty = (rdata_r.status == SLOT_EMPTY);
  assign slot_tomb  = (rdata_r.status == SLOT_TOMB);
  assign slot_match = (rdata_r.status == SLOT_LIVE) && (rdata_r.key == key_r);

  assign is_get = (cmd_r == CMD_GET);
  assign is_set = (cmd_r == CMD_SET);
  assign is_del = (cmd_r == CMD_DEL);

  assign need_probe = ((in_cmd == CMD_GET) && (used_r != '0)) ||
                      ((in_cmd == CMD_DEL) && !frozen && (used_r != '0)) ||
                      ((in_cmd == CMD_SET) && !frozen);

  assign room   = empty_r && (used_r < LIMIT_C);
  assign dst_ok = hit_r || tomb_seen_r || room;

  assign stat.clr_last   = (clr_r == LAST_IDX);
  assign stat.need_probe = need_probe;
  assign stat.mod_bypass = POW2;
  assign stat.mod_last   = (mod_cnt_r == MOD_REM);
  assign stat.probe_stop = slot_empty || slot_match || (visit_r == LAST_IDX);
  assign stat.out_free   = !out_valid_r || out_ready;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ev_addr_r;
    mem_wdata.status = is_set ? SLOT_LIVE : SLOT_TOMB;
    mem_wdata.key    = key_r;
    mem_wdata.value  = is_set ? val_r : hit_val_r;
    if (cmd.clr_step) begin
      mem_we    = 1'b1;
      mem_waddr = clr_r;
      mem_wdata = '0;
    end else if (cmd.finish && probe_ran_r) begin
      if (is_set && dst_ok) begin
        mem_we = 1'b1;
        if (!hit_r && tomb_seen_r) begin
          mem_waddr = tomb_addr_r;
        end
      end else if (is_del && hit_r) begin
        mem_we = 1'b1;
      end
    end
  end

  always_comb begin
    res_status = STS_NOTFOUND;
    res_new    = 1'b0;
    res_rval   = '0;
    res_svalid = probe_ran_r && global_mode;
    if (!probe_ran_r) begin
      if ((is_set || is_del) && frozen) begin
        res_status = STS_FROZEN;
      end
    end else if (is_set) begin
      res_status = dst_ok ? STS_OK : STS_FULL;
      res_new    = dst_ok && !hit_r;
    end else if (hit_r) begin
      res_status = STS_OK;
      if (is_get) begin
        res_rval = hit_val_r;
      end
    end
  end

  assign sidx_ext = {8'b0, ev_addr_r};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[base_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_r       <= in_cmd;
      key_r       <= in_key_id;
      val_r       <= in_write_value;
      hash_r      <= in_key_hash;
      rem_r       <= '0;
      mod_cnt_r   <= '0;
      probe_ran_r <= need_probe;
    end
    if (cmd.mod_step) begin
      case (mod_cnt_r)
        MOD_MUL: begin
          mh_r <= mul_full[2*HASH_W-1:HASH_W];
        end
        MOD_QUO: begin
          quo_r <= quo_nxt;
        end
        default: begin
          rem_r <= rem_full[IDX_W-1:0];
        end
      endcase
      mod_cnt_r <= mod_cnt_r + 1'b1;
    end
    if (cmd.prime) begin
      addr_r      <= addr_inc;
      ev_addr_r   <= base_addr;
      visit_r     <= '0;
      tomb_seen_r <= 1'b0;
    end
    if (cmd.probe_step) begin
      if (slot_tomb && !tomb_seen_r) begin
        tomb_seen_r <= 1'b1;
        tomb_addr_r <= ev_addr_r;
      end
      if (stat.probe_stop) begin
        hit_r     <= slot_match;
        empty_r   <= slot_empty;
        hit_val_r <= rdata_r.value;
      end else begin
        addr_r    <= addr_inc;
        ev_addr_r <= base_addr;
        visit_r   <= visit_r + 1'b1;
      end
    end
    if (cmd.finish) begin
      out_status           <= res_status;
      out_is_new_key       <= res_new;
      out_read_value       <= res_rval;
      out_slot_index       <= res_svalid ? sidx_ext[7:0] : '0;
      out_slot_index_valid <= res_svalid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_step) begin
        clr_r <= clr_r + 1'b1;
      end
      if (cmd.finish && probe_ran_r && is_set && !hit_r && !tomb_seen_r && room) begin
        used_r <= used_r + 1'b1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== design/open_addressing_hash_table_core.sv =====
// Flow: an accepted get, set or delete probes the table slot by slot from its start slot;
// when CAPACITY is not a power of two, the multiply, quotient and remainder steps first compute the hash remainder.
// Items that need no probe go straight to the result. A result waits while the output is held.
// Throughput: one item at a time; the probe loop reads one slot per cycle from the table.
// Reset: synchronous, active low; the table then clears one slot per cycle, every slot
// before the first beat is accepted. Configuration writes are taken throughout.
module open_addressing_hash_table_core
  import oaht_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_cmd,
  input  logic [KEY_W-1:0]   in_key_id,
  input  logic [HASH_W-1:0]  in_key_hash,
  input  logic [VALUE_W-1:0] in_write_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic               out_is_new_key,
  output logic [VALUE_W-1:0] out_read_value,
  output logic [SIDX_W-1:0]  out_slot_index,
  output logic               out_slot_index_valid
);

  localparam logic REG_FROZEN = 1'b0;
  localparam logic REG_GLOBAL = 1'b1;

  logic       frozen_r;
  logic       global_mode_r;
  logic       cfg_wr;
  oaht_cmd_t  cmd;
  oaht_stat_t stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frozen_r      <= 1'b0;
      global_mode_r <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_FROZEN) begin
        frozen_r <= pwdata[0];
      end
      if (paddr[2] == REG_GLOBAL) begin
        global_mode_r <= pwdata[0];
      end
    end
  end

  assign prdata = {31'b0, (paddr[2] == REG_GLOBAL) ? global_mode_r : frozen_r};

  oaht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  oaht_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .stat                 (stat),
    .frozen               (frozen_r),
    .global_mode          (global_mode_r),
    .in_cmd               (in_cmd),
    .in_key_id            (in_key_id),
    .in_key_hash          (in_key_hash),
    .in_write_value       (in_write_value),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_status           (out_status),
    .out_is_new_key       (out_is_new_key),
    .out_read_value       (out_read_value),
    .out_slot_index       (out_slot_index),
    .out_slot_index_valid (out_slot_index_valid)
  );

endmodule
